/* src/dlcf_pkg.sv */
// Package for the delayed linear color fade engine.
// Holds the widths, opcodes and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package dlcf_pkg;

  localparam int CH_W      = 24;
  localparam int NCH       = 4;
  localparam int CH_IDX_W  = $clog2(NCH);
  localparam int STEP_W    = CH_W + 1;
  localparam int SUM_W     = CH_W + 2;
  localparam int FT_W      = 16;
  localparam int TICK_W    = FT_W + 1;
  localparam int OP_W      = 2;
  localparam int DIV_CNT_W = $clog2(CH_W + 2);

  localparam int IN_BITS     = NCH * CH_W + 2 * FT_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = NCH * CH_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_START  = 2'd1;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;

  typedef struct packed {
    logic load_in;
    logic apply_start;
    logic apply_cancel;
    logic div_start;
    logic emit;
  } dlcf_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            need_div;
    logic            div_done;
    logic            out_free;
  } dlcf_sts_t;

endpackage

/* src/dlcf_ctrl.sv */
// Controller state machine for the color fade engine.
// Issues commands to dlcf_dpath and sequences decode, divide and emit.
// Depends on dlcf_pkg.
`timescale 1ns / 1ps

module dlcf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_tvalid_i,
  output logic                in_tready_o,
  input  dlcf_pkg::dlcf_sts_t sts_i,
  output dlcf_pkg::dlcf_cmd_t cmd_o
);
  import dlcf_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_DIV    = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_tready_o = 1'b1;
        if (in_tvalid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts_i.op)
          OP_START: begin
            cmd_o.apply_start = 1'b1;
            state_d           = ST_IDLE;
          end
          OP_CANCEL: begin
            cmd_o.apply_cancel = 1'b1;
            state_d            = ST_IDLE;
          end
          OP_TICK: begin
            if (sts_i.need_div) begin
              cmd_o.div_start = 1'b1;
              state_d         = ST_DIV;
            end else begin
              state_d = ST_EMIT;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/dlcf_dpath.sv */
// Datapath of the color fade engine: input latch, fade state, shared
// restoring divider for the per-channel steps, add/clamp and output register.
// Depends on dlcf_pkg; driven by dlcf_ctrl.
`timescale 1ns / 1ps

module dlcf_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [dlcf_pkg::IN_TDATA_W-1:0]     in_tdata_i,
  input  logic [dlcf_pkg::OP_W-1:0]           in_tuser_i,
  input  dlcf_pkg::dlcf_cmd_t                 cmd_i,
  output dlcf_pkg::dlcf_sts_t                 sts_o,
  output logic                                out_tvalid_o,
  input  logic                                out_tready_i,
  output logic [dlcf_pkg::OUT_TDATA_W-1:0]    out_tdata_o,
  output logic                                out_tuser_o
);
  import dlcf_pkg::*;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST_BIT = DIV_CNT_W'(CH_W);
  localparam logic [DIV_CNT_W-1:0] CNT_STORE    = DIV_CNT_W'(CH_W + 1);
  localparam logic [CH_IDX_W-1:0]  CH_LAST      = CH_IDX_W'(NCH - 1);

  // input latch
  logic [OP_W-1:0] op_q;
  logic [CH_W-1:0] cur_q [NCH];
  logic [FT_W-1:0] fade_in_q;
  logic [FT_W-1:0] wait_in_q;
  logic [CH_W-1:0] in_chan [NCH];

  // fade state
  logic [CH_W-1:0]   tgt_q  [NCH];
  logic [STEP_W-1:0] step_q [NCH];
  logic [FT_W-1:0]   ramp_q;
  logic [FT_W-1:0]   wait_q;
  logic [TICK_W-1:0] tick_q;
  logic              act_q;

  // divider
  logic                 busy_q;
  logic [CH_IDX_W-1:0]  ch_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [FT_W-1:0]      rem_q;
  logic [CH_W-1:0]      dvd_q;
  logic                 neg_q;

  logic [STEP_W-1:0] diff;
  logic [STEP_W-1:0] mag;
  logic [FT_W:0]     sh;
  logic [FT_W:0]     trial;
  logic [STEP_W-1:0] quo_ext;
  logic [STEP_W-1:0] step_new;
  logic              div_done;

  // tick evaluation
  logic              ramp_on;
  logic [TICK_W-1:0] tick_nxt;
  logic              fade_end;
  logic [SUM_W-1:0]  sum [NCH];
  logic [CH_W-1:0]   res [NCH];

  // output register
  logic            out_valid_q;
  logic [CH_W-1:0] out_chan_q [NCH];
  logic            out_fading_q;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      in_chan[c] = in_tdata_i[c*CH_W +: CH_W];
    end
  end

  always_comb begin
    diff     = {1'b0, tgt_q[ch_q]} - {1'b0, cur_q[ch_q]};
    mag      = diff[STEP_W-1] ? (~diff + 1'b1) : diff;
    sh       = {rem_q, dvd_q[CH_W-1]};
    trial    = sh - {1'b0, ramp_q};
    quo_ext  = {1'b0, dvd_q};
    step_new = neg_q ? (~quo_ext + 1'b1) : quo_ext;
    div_done = busy_q && (cnt_q == CNT_STORE) && (ch_q == CH_LAST);
  end

  always_comb begin
    ramp_on  = act_q && (tick_q >= {1'b0, wait_q});
    tick_nxt = tick_q + 1'b1;
    fade_end = tick_nxt >= ({1'b0, ramp_q} + {1'b0, wait_q});
    for (int c = 0; c < NCH; c++) begin
      sum[c] = {2'b00, cur_q[c]} + {step_q[c][STEP_W-1], step_q[c]};
      if (sum[c][SUM_W-1]) begin
        res[c] = '0;
      end else if (sum[c][CH_W]) begin
        res[c] = '1;
      end else begin
        res[c] = sum[c][CH_W-1:0];
      end
      if (!ramp_on) begin
        res[c] = cur_q[c];
      end
    end
  end

  always_comb begin
    sts_o.op       = op_q;
    sts_o.need_div = act_q && (tick_q == {1'b0, wait_q});
    sts_o.div_done = div_done;
    sts_o.out_free = !out_valid_q || out_tready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q      <= in_tuser_i;
      cur_q     <= in_chan;
      fade_in_q <= in_tdata_i[NCH*CH_W +: FT_W];
      wait_in_q <= in_tdata_i[NCH*CH_W+FT_W +: FT_W];
    end
    if (busy_q) begin
      if (cnt_q == '0) begin
        dvd_q <= mag[CH_W-1:0];
        rem_q <= '0;
        neg_q <= diff[STEP_W-1];
      end else if (cnt_q <= CNT_LAST_BIT) begin
        rem_q <= trial[FT_W] ? sh[FT_W-1:0] : trial[FT_W-1:0];
        dvd_q <= {dvd_q[CH_W-2:0], ~trial[FT_W]};
      end
    end
    if (cmd_i.emit) begin
      out_chan_q   <= res;
      out_fading_q <= act_q && !fade_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NCH; c++) begin
        tgt_q[c]  <= '0;
        step_q[c] <= '0;
      end
      ramp_q      <= '0;
      wait_q      <= '0;
      tick_q      <= '0;
      act_q       <= 1'b0;
      busy_q      <= 1'b0;
      ch_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.apply_start) begin
        tgt_q  <= cur_q;
        ramp_q <= (fade_in_q == '0) ? FT_W'(1) : fade_in_q;
        wait_q <= wait_in_q;
        tick_q <= '0;
        act_q  <= 1'b1;
      end
      if (cmd_i.apply_cancel) begin
        tick_q <= '0;
        act_q  <= 1'b0;
      end
      if (cmd_i.emit && act_q) begin
        if (fade_end) begin
          tick_q <= '0;
          act_q  <= 1'b0;
        end else begin
          tick_q <= tick_nxt;
        end
      end

      if (cmd_i.div_start) begin
        busy_q <= 1'b1;
        ch_q   <= '0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_STORE) begin
          step_q[ch_q] <= step_new;
          cnt_q        <= '0;
          if (ch_q == CH_LAST) begin
            busy_q <= 1'b0;
          end else begin
            ch_q <= ch_q + 1'b1;
          end
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    out_tdata_o = '0;
    for (int c = 0; c < NCH; c++) begin
      out_tdata_o[c*CH_W +: CH_W] = out_chan_q[c];
    end
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tuser_o  = out_fading_q;

endmodule

/* src/delayed_linear_color_fade.sv */
// Channel   Dir  tdata (low bit up)                                   tuser
// s_axis    in   chan_red, chan_green, chan_blue, chan_alpha,         opcode
//                fade_ticks, wait_ticks
// m_axis    out  out_red, out_green, out_blue, out_alpha              still_fading
//
// One item at a time. Start, cancel and unused opcodes pass decode to idle.
// A tick passes decode and emit, and also a divide state on the tick that
// computes the steps: one shared restoring divider serves the four channels
// in turn. The result waits in an output register; the next item is taken
// meanwhile; a tick stalls only in the emit state until the register frees.
// Reset is asynchronous, active low, and leaves the engine idle.
// Top level of the delayed linear color fade engine; instantiates
// dlcf_ctrl and dlcf_dpath, depends on dlcf_pkg.
`timescale 1ns / 1ps

module delayed_linear_color_fade (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // chan_red, chan_green, chan_blue, chan_alpha, fade_ticks, wait_ticks
  input  logic [dlcf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // opcode
  input  logic [dlcf_pkg::OP_W-1:0]           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [dlcf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // still_fading
  output logic                                m_axis_tuser
);
  import dlcf_pkg::*;

  dlcf_cmd_t cmd;
  dlcf_sts_t sts;

  dlcf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_tready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dlcf_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_tvalid_o (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .out_tdata_o  (m_axis_tdata),
    .out_tuser_o  (m_axis_tuser)
  );

endmodule
